// ===== rtl/core/css_pkg.sv =====
package css_pkg;

  localparam int COORD_W = 32;
  localparam int ACC_W = 40;
  localparam int STEP_W = 16;
  localparam int CNT_W = 6;
  localparam int MAX_SAMPLES = 64;
  localparam int MAX_DIMS = 3;
  localparam int LANES = 2 * MAX_DIMS;

  localparam logic [1:0] REG_KIND = 2'd0;
  localparam logic [1:0] REG_STEP = 2'd1;
  localparam logic [1:0] REG_DIMS = 2'd2;

  localparam logic KIND_BSPLINE = 1'b0;
  localparam logic KIND_CATMULL = 1'b1;

  localparam logic [17:0] RECIP3_17 = 18'd174763;
  localparam logic [19:0] RECIP3_19 = 20'd699051;

  typedef struct packed {
    logic       shift_in;
    logic       coef;
    logic       load;
    logic       step;
    logic [1:0] step_idx;
    logic       fin1;
    logic       fin2;
    logic       fin3;
    logic       advance;
  } css_cmd_t;

  typedef struct packed {
    logic last;
  } css_status_t;

endpackage

// ===== rtl/core/cubic_spline_segment_sampler.sv =====
// Cubic spline segment sampler (uniform B-spline or Catmull-Rom).
// Point channel: point_valid/point_stall carry one control point (Q16.16
// x, y, z) and a restart flag that starts a new curve. The last four points
// are kept; from the fourth point of a curve on, each point opens a segment.
// Sample channel: sample_valid/sample_stall carry position, tangent and
// last_sample for s = 0, step, 2*step, ... while s < 1, at most 64 samples.
// Each sample passes through the shared Horner and rounding path (a
// coefficient step per segment, then load, three Horner steps, three
// rounding stages and an output state). A point that does not complete a
// segment is taken without a stall. point_stall stays high while a segment
// is sampled.
// When the receiver stalls, the current sample holds on the outputs and
// sampling pauses. Reset empties the point window and loads the register
// defaults: Catmull-Rom, step 6554, three dimensions. Registers are written
// over the APB port at 0x0 (kind), 0x4 (step), 0x8 (dims); the user must
// write them only while idle, which the block itself does not enforce.
module cubic_spline_segment_sampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                point_valid,
  output logic                                point_stall,
  input  logic signed [css_pkg::COORD_W-1:0]  point_x,
  input  logic signed [css_pkg::COORD_W-1:0]  point_y,
  input  logic signed [css_pkg::COORD_W-1:0]  point_z,
  input  logic                                restart,
  output logic                                sample_valid,
  input  logic                                sample_stall,
  output logic signed [css_pkg::COORD_W-1:0]  pos_x,
  output logic signed [css_pkg::COORD_W-1:0]  pos_y,
  output logic signed [css_pkg::COORD_W-1:0]  pos_z,
  output logic signed [css_pkg::COORD_W-1:0]  tan_x,
  output logic signed [css_pkg::COORD_W-1:0]  tan_y,
  output logic signed [css_pkg::COORD_W-1:0]  tan_z,
  output logic                                last_sample
);
  import css_pkg::*;

  logic              spline_kind;
  logic [STEP_W-1:0] step_size;
  logic [1:0]        dims_used;
  css_cmd_t          cmd;
  css_status_t       status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spline_kind <= KIND_CATMULL;
      step_size <= STEP_W'(6554);
      dims_used <= 2'd3;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_KIND: spline_kind <= pwdata[0];
        REG_STEP: step_size <= pwdata[STEP_W-1:0];
        REG_DIMS: dims_used <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_KIND: prdata = {31'd0, spline_kind};
      REG_STEP: prdata = {16'd0, step_size};
      REG_DIMS: prdata = {30'd0, dims_used};
      default:  prdata = '0;
    endcase
  end

  css_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .restart      (restart),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  css_datapath u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .spline_kind (spline_kind),
    .step_size   (step_size),
    .dims_used   (dims_used),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .tan_x       (tan_x),
    .tan_y       (tan_y),
    .tan_z       (tan_z),
    .last_sample (last_sample)
  );

`ifndef SYNTHESIS
  a_idle_no_sample: assert property (@(posedge clk) disable iff (rst)
    !point_stall |-> !sample_valid)
    else $error("sample shown while taking points");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && last_sample |=> !point_stall)
    else $error("point channel still stalled after final sample");

  a_restart_no_segment: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_stall && restart |=> !point_stall)
    else $error("restart point opened a segment");
`endif

endmodule

// ===== rtl/core/css_datapath.sv =====
module css_datapath (
  input  logic                                clk,
  input  css_pkg::css_cmd_t                   cmd,
  output css_pkg::css_status_t                status,
  input  logic signed [css_pkg::COORD_W-1:0]  point_x,
  input  logic signed [css_pkg::COORD_W-1:0]  point_y,
  input  logic signed [css_pkg::COORD_W-1:0]  point_z,
  input  logic                                spline_kind,
  input  logic [css_pkg::STEP_W-1:0]          step_size,
  input  logic [1:0]                          dims_used,
  output logic signed [css_pkg::COORD_W-1:0]  pos_x,
  output logic signed [css_pkg::COORD_W-1:0]  pos_y,
  output logic signed [css_pkg::COORD_W-1:0]  pos_z,
  output logic signed [css_pkg::COORD_W-1:0]  tan_x,
  output logic signed [css_pkg::COORD_W-1:0]  tan_y,
  output logic signed [css_pkg::COORD_W-1:0]  tan_z,
  output logic                                last_sample
);
  import css_pkg::*;

  logic signed [COORD_W-1:0] win [4][MAX_DIMS];
  logic signed [ACC_W-1:0]   c [MAX_DIMS][4];
  logic signed [ACC_W-1:0]   c_new [MAX_DIMS][4];
  logic signed [ACC_W-1:0]   acc [LANES];
  logic signed [ACC_W-1:0]   acc_next [LANES];
  logic signed [ACC_W-1:0]   xr [LANES];
  logic [15:0]               qh [LANES];
  logic [1:0]                rh [LANES];
  logic [16:0]               yl [LANES];
  logic                      hi [LANES];
  logic                      lo [LANES];
  logic signed [COORD_W-1:0] crv [LANES];
  logic signed [COORD_W-1:0] res [LANES];
  logic [STEP_W-1:0]         s;
  logic [CNT_W-1:0]          n;
  logic [1:0]                dims_eff;
  logic [STEP_W:0]           s_sum;

  assign s_sum = {1'b0, s} + {1'b0, step_size};
  assign status.last = (n == CNT_W'(MAX_SAMPLES - 1)) || s_sum[STEP_W];
  assign dims_eff = (dims_used == 2'd0) ? 2'd1 : dims_used;

  always_comb begin
    logic signed [ACC_W-1:0] p0, p1, p2, p3;
    for (int d = 0; d < MAX_DIMS; d++) begin
      p0 = ACC_W'(win[0][d]);
      p1 = ACC_W'(win[1][d]);
      p2 = ACC_W'(win[2][d]);
      p3 = ACC_W'(win[3][d]);
      c_new[d][0] = p3 - p0 + 40'sd3 * (p1 - p2);
      if (spline_kind == KIND_CATMULL) begin
        c_new[d][1] = 40'sd2 * p0 - 40'sd5 * p1 + 40'sd4 * p2 - p3;
        c_new[d][2] = p2 - p0;
        c_new[d][3] = 40'sd2 * p1;
      end else begin
        c_new[d][1] = 40'sd3 * (p0 + p2) - 40'sd6 * p1;
        c_new[d][2] = 40'sd3 * (p2 - p0);
        c_new[d][3] = p0 + 40'sd4 * p1 + p2;
      end
    end
  end

  always_comb begin
    logic signed [56:0]      prod;
    logic signed [56:0]      rnd;
    logic signed [ACC_W-1:0] addend;
    for (int d = 0; d < MAX_DIMS; d++) begin
      prod = 57'(acc[d]) * $signed({41'd0, s});
      rnd = (prod + 57'sd32768) >>> 16;
      acc_next[d] = ACC_W'(rnd) + c[d][cmd.step_idx + 2'd1];
      prod = 57'(acc[d + MAX_DIMS]) * $signed({41'd0, s});
      rnd = (prod + 57'sd32768) >>> 16;
      if (cmd.step_idx == 2'd0) begin
        addend = c[d][1] <<< 1;
      end else begin
        addend = c[d][2];
      end
      if (cmd.step_idx == 2'd2) begin
        acc_next[d + MAX_DIMS] = acc[d + MAX_DIMS];
      end else begin
        acc_next[d + MAX_DIMS] = ACC_W'(rnd) + addend;
      end
    end
  end

  always_comb begin
    logic [33:0] q;
    logic [18:0] z;
    logic [38:0] pz;
    logic signed [COORD_W-1:0] bsv;
    for (int l = 0; l < LANES; l++) begin
      z = {rh[l], yl[l]};
      pz = 39'(z) * 39'(RECIP3_19);
      q = {1'b0, qh[l], 17'd0} + 34'(pz[38:21]);
      bsv = {~q[31], q[30:0]};
      if (hi[l]) begin
        bsv = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (lo[l]) begin
        bsv = {1'b1, {(COORD_W-1){1'b0}}};
      end
      if ((l % MAX_DIMS) >= int'(dims_eff)) begin
        res[l] = '0;
      end else if (spline_kind == KIND_CATMULL) begin
        res[l] = crv[l];
      end else begin
        res[l] = bsv;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] y;
    logic [34:0]             ph;
    logic [16:0]             yh;
    if (cmd.shift_in) begin
      for (int i = 0; i < 3; i++) begin
        for (int d = 0; d < MAX_DIMS; d++) begin
          win[i][d] <= win[i + 1][d];
        end
      end
      win[3][0] <= point_x;
      win[3][1] <= point_y;
      win[3][2] <= point_z;
    end
    if (cmd.coef) begin
      c <= c_new;
      s <= '0;
      n <= '0;
    end
    if (cmd.advance) begin
      s <= s_sum[STEP_W-1:0];
      n <= n + CNT_W'(1);
    end
    if (cmd.load) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        acc[d] <= c[d][0];
        acc[d + MAX_DIMS] <= 40'sd3 * c[d][0];
      end
    end
    if (cmd.step) begin
      acc <= acc_next;
    end
    for (int l = 0; l < LANES; l++) begin
      if (cmd.fin1) begin
        xr[l] <= (acc[l] + ((spline_kind == KIND_CATMULL) ? 40'sd1 : 40'sd3)) >>> 1;
      end
      if (cmd.fin2) begin
        y = xr[l] + 40'sd6442450944;
        yh = y[33:17];
        ph = 35'(yh) * 35'(RECIP3_17);
        qh[l] <= ph[34:19];
        rh[l] <= 2'(yh - 17'(ph[34:19]) * 17'd3);
        yl[l] <= y[16:0];
        hi[l] <= xr[l] >= 40'sd6442450944;
        lo[l] <= xr[l] < -40'sd6442450944;
        if (xr[l] > 40'sd2147483647) begin
          crv[l] <= {1'b0, {(COORD_W-1){1'b1}}};
        end else if (xr[l] < -40'sd2147483648) begin
          crv[l] <= {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
          crv[l] <= xr[l][COORD_W-1:0];
        end
      end
    end
    if (cmd.fin3) begin
      pos_x <= res[0];
      pos_y <= res[1];
      pos_z <= res[2];
      tan_x <= res[3];
      tan_y <= res[4];
      tan_z <= res[5];
      last_sample <= status.last;
    end
  end

endmodule

// ===== rtl/core/css_ctrl.sv =====
module css_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 point_valid,
  output logic                 point_stall,
  input  logic                 restart,
  output logic                 sample_valid,
  input  logic                 sample_stall,
  input  css_pkg::css_status_t status,
  output css_pkg::css_cmd_t    cmd
);
  import css_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COEF, ST_LOAD, ST_H1, ST_H2, ST_H3, ST_F1, ST_F2, ST_F3, ST_OUT
  } state_t;

  state_t     state;
  logic [2:0] held;
  logic [2:0] held_next;

  assign point_stall = (state != ST_IDLE);
  assign sample_valid = (state == ST_OUT);
  assign held_next = restart ? 3'd1 : ((held == 3'd4) ? 3'd4 : held + 3'd1);

  always_comb begin
    cmd = '0;
    cmd.shift_in = (state == ST_IDLE) && point_valid;
    cmd.coef = (state == ST_COEF);
    cmd.load = (state == ST_LOAD);
    cmd.step = (state == ST_H1) || (state == ST_H2) || (state == ST_H3);
    cmd.step_idx = (state == ST_H2) ? 2'd1 : ((state == ST_H3) ? 2'd2 : 2'd0);
    cmd.fin1 = (state == ST_F1);
    cmd.fin2 = (state == ST_F2);
    cmd.fin3 = (state == ST_F3);
    cmd.advance = (state == ST_OUT) && !sample_stall && !status.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      held <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (point_valid) begin
            held <= held_next;
            if (held_next == 3'd4) begin
              state <= ST_COEF;
            end
          end
        end
        ST_COEF: state <= ST_LOAD;
        ST_LOAD: state <= ST_H1;
        ST_H1:   state <= ST_H2;
        ST_H2:   state <= ST_H3;
        ST_H3:   state <= ST_F1;
        ST_F1:   state <= ST_F2;
        ST_F2:   state <= ST_F3;
        ST_F3:   state <= ST_OUT;
        ST_OUT: begin
          if (!sample_stall) begin
            state <= status.last ? ST_IDLE : ST_LOAD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
